[src/ddef_pkg.sv]
// Shared types, register indexes and helper functions of the diagonal difference edge filter.
package ddef_pkg;

    localparam int unsigned CfgIdxWidth = 1;
    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned FrameWidthBits = 12;
    localparam int unsigned RowWidth = 16;
    localparam int unsigned ChanWidth = 8;
    localparam int unsigned PixWidth = 3 * ChanWidth;

    localparam logic [CfgIdxWidth-1:0] REG_FRAME_WIDTH = 1'd0;
    localparam logic [CfgIdxWidth-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FrameWidthBits-1:0] FRAME_WIDTH_RESET = 12'd640;
    localparam logic [RowWidth-1:0] FRAME_HEIGHT_RESET = 16'd480;

    typedef struct packed {
        logic [ChanWidth-1:0] blue;
        logic [ChanWidth-1:0] green;
        logic [ChanWidth-1:0] red;
    } t_pixel;

    // Line buffer strobes driven by the filter control.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_lb_ctrl;

    function automatic logic [ChanWidth-1:0] absdiff8(input logic [ChanWidth-1:0] a,
                                                      input logic [ChanWidth-1:0] b);
        absdiff8 = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

[src/ddef_line_buf.sv]
// Two row line buffers: the row one back and the row two back, read and written by column.
module ddef_line_buf #(
    parameter int unsigned MAX_WIDTH = 2048,
    parameter int unsigned COL_WIDTH = 11
) (
    input  logic                   i_clk,
    input  ddef_pkg::t_lb_ctrl     i_ctrl,
    input  logic [COL_WIDTH-1:0]   i_rd_addr,
    input  logic [COL_WIDTH-1:0]   i_wr_addr,
    input  ddef_pkg::t_pixel       i_wr_pix,
    output ddef_pkg::t_pixel       o_rd_two
);
    import ddef_pkg::*;

    t_pixel r_mem_two [MAX_WIDTH];
    t_pixel r_mem_one [MAX_WIDTH];
    t_pixel r_rd_two;
    t_pixel r_rd_one;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_two <= r_mem_two[i_rd_addr];
            r_rd_one <= r_mem_one[i_rd_addr];
        end
        // The row shifts down: the pixel read one back for this column moves to two back.
        if (i_ctrl.wr_en) begin
            r_mem_two[i_wr_addr] <= r_rd_one;
            r_mem_one[i_wr_addr] <= i_wr_pix;
        end
    end

    assign o_rd_two = r_rd_two;

endmodule

[src/diagonal_difference_edge_filter_top.sv]
// Top level of the diagonal difference edge filter over an RGB888 raster stream.
//
// Pixels enter in raster order, one transaction per clock at full rate, held back when the
// output stalls. For each interior pixel (x,y) one result leaves when pixel (x+1,y+1) has been
// taken: red is |red(x-1,y-1) - red(x+1,y+1)|, green is |green(x+1,y-1) - green(x-1,y+1)|,
// blue is |blue(x-1,y-1) - blue(x-1,y+1)|, with the column and row of (x,y); tlast marks the
// last result of the frame. Border pixels give no result. On its way out a pixel passes the
// registered line buffer read at its column and then the differences, which are written to
// the output register. The line buffers hold MAX_WIDTH pixels per row; the frame size comes from
// the two configuration registers, clamped to at least 3 and a width of at most MAX_WIDTH, and
// should be changed only between frames. Line buffers are not cleared at reset.
module diagonal_difference_edge_filter_top #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ddef_pkg::CfgIdxWidth-1:0]      i_cfg_addr,
    input  logic [ddef_pkg::CfgDataWidth-1:0]     i_cfg_wdata,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata, lowest bit first: pix_red[7:0], pix_green[7:0], pix_blue[7:0]
    input  logic [23:0]                           i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tdata, lowest bit first: edge_red[7:0], edge_green[7:0], edge_blue[7:0],
    // out_col[COL_WIDTH-1:0], out_row[15:0], then zero fill to a whole byte
    output logic [(((40 + $clog2(MAX_WIDTH)) + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // tlast: frame_done
    output logic                                  o_m_axis_tlast
);
    import ddef_pkg::*;

    localparam int unsigned COL_WIDTH = $clog2(MAX_WIDTH);
    localparam int unsigned PAYLOAD_BITS = 3 * ChanWidth + COL_WIDTH + RowWidth;
    localparam int unsigned OUT_DW = ((PAYLOAD_BITS + 7) / 8) * 8;
    localparam int unsigned PAD_BITS = OUT_DW - PAYLOAD_BITS;
    localparam int unsigned SIZE_BITS = 17;

    logic [FrameWidthBits-1:0] r_frame_width;
    logic [RowWidth-1:0]       r_frame_height;

    logic [COL_WIDTH-1:0] r_col;
    logic [RowWidth-1:0]  r_row;
    logic [COL_WIDTH-1:0] n_col;
    logic [RowWidth-1:0]  n_row;

    logic                 r_s1_valid;
    logic                 r_s1_emit;
    logic                 r_s1_last;
    t_pixel               r_s1_pix;
    logic [COL_WIDTH-1:0] r_s1_col;
    logic [RowWidth-1:0]  r_s1_row;

    t_pixel r_top_tail [2];
    t_pixel r_row_tail [2];

    logic                 r_out_valid;
    logic [ChanWidth-1:0] r_out_red;
    logic [ChanWidth-1:0] r_out_green;
    logic [ChanWidth-1:0] r_out_blue;
    logic [COL_WIDTH-1:0] r_out_col;
    logic [RowWidth-1:0]  r_out_row;
    logic                 r_out_last;

    logic                 advance;
    logic                 accept;
    logic [SIZE_BITS-1:0] width_eff;
    logic [SIZE_BITS-1:0] height_eff;
    logic                 last_col;
    logic                 last_row;
    t_pixel               in_pix;
    t_pixel               rd_two;
    t_lb_ctrl             lb_ctrl;

    // The whole pipeline moves together whenever the output register can take a result.
    assign advance = !r_out_valid || i_m_axis_tready;
    assign accept = advance && i_s_axis_tvalid;
    assign o_s_axis_tready = advance;

    assign in_pix.red = i_s_axis_tdata[7:0];
    assign in_pix.green = i_s_axis_tdata[15:8];
    assign in_pix.blue = i_s_axis_tdata[23:16];

    always_comb begin
        width_eff = SIZE_BITS'(r_frame_width);
        if (width_eff < SIZE_BITS'(3)) begin
            width_eff = SIZE_BITS'(3);
        end else if (width_eff > SIZE_BITS'(MAX_WIDTH)) begin
            width_eff = SIZE_BITS'(MAX_WIDTH);
        end
        height_eff = SIZE_BITS'(r_frame_height);
        if (height_eff < SIZE_BITS'(3)) begin
            height_eff = SIZE_BITS'(3);
        end
    end

    assign last_col = (SIZE_BITS'(r_col) + SIZE_BITS'(1)) >= width_eff;
    assign last_row = (SIZE_BITS'(r_row) + SIZE_BITS'(1)) >= height_eff;

    always_comb begin
        n_col = r_col + COL_WIDTH'(1);
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : (r_row + RowWidth'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FRAME_WIDTH: r_frame_width <= i_cfg_wdata[FrameWidthBits-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[RowWidth-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_s_axis_tvalid;
            r_out_valid <= r_s1_valid && r_s1_emit;
            if (i_s_axis_tvalid) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= in_pix;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_emit <= (r_row >= RowWidth'(2)) && (r_col >= COL_WIDTH'(2));
            r_s1_last <= last_col && last_row;
        end
    end

    assign lb_ctrl.rd_en = accept;
    assign lb_ctrl.wr_en = advance && r_s1_valid;

    ddef_line_buf #(
        .MAX_WIDTH(MAX_WIDTH),
        .COL_WIDTH(COL_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_ctrl    (lb_ctrl),
        .i_rd_addr (r_col),
        .i_wr_addr (r_s1_col),
        .i_wr_pix  (r_s1_pix),
        .o_rd_two  (rd_two)
    );

    // Tails hold the last two pixels of the current row and of the row two back.
    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_top_tail[1] <= r_top_tail[0];
            r_top_tail[0] <= rd_two;
            r_row_tail[1] <= r_row_tail[0];
            r_row_tail[0] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid && r_s1_emit) begin
            r_out_red <= absdiff8(r_top_tail[1].red, r_s1_pix.red);
            r_out_green <= absdiff8(rd_two.green, r_row_tail[1].green);
            r_out_blue <= absdiff8(r_top_tail[1].blue, r_row_tail[1].blue);
            r_out_col <= r_s1_col - COL_WIDTH'(1);
            r_out_row <= r_s1_row - RowWidth'(1);
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast = r_out_last;
    assign o_m_axis_tdata = {{PAD_BITS{1'b0}}, r_out_row, r_out_col,
                             r_out_blue, r_out_green, r_out_red};

endmodule

[tb/sv/edge_result_checker.sv]
// Checker that predicts and compares the edge results of the diagonal difference edge filter.
`timescale 1ns / 1ps

module edge_result_checker #(
    parameter int unsigned MAX_W = 2048,
    parameter int unsigned OUT_W = 56
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ddef_pkg::CfgIdxWidth-1:0]    i_cfg_addr,
    input  logic [ddef_pkg::CfgDataWidth-1:0]   i_cfg_wdata,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // tdata, lowest bit first: pix_red[7:0], pix_green[7:0], pix_blue[7:0]
    input  logic [23:0]                         i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // tdata, lowest bit first: edge_red, edge_green, edge_blue, out_col, out_row, zero fill
    input  logic [OUT_W-1:0]                    i_m_tdata,
    // tlast: frame_done
    input  logic                                i_m_tlast,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_pixels_seen,
    output int                                  o_results_seen
);
    import ddef_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_W);

    typedef struct {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [COL_W-1:0] col;
        logic [15:0]      row;
        logic             done;
    } t_edge_result;

    t_edge_result    expected_edges[$];
    t_pixel          two_back[MAX_W];
    t_pixel          one_back[MAX_W];
    t_pixel          row_tail[2];
    t_pixel          top_tail[2];
    logic [11:0]     width_reg;
    logic [15:0]     height_reg;
    int unsigned     col_pos;
    int unsigned     row_pos;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_pixels_seen = 0;
        o_results_seen = 0;
    end

    function automatic logic [7:0] chan_distance(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // One raster step: the pixel that completes the 3x3 window of (col-1,row-1).
    task automatic predict_pixel(input t_pixel px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        int unsigned      row;
        bit               last_col;
        bit               last_row;
        logic [COL_W-1:0] idx;
        t_pixel           top;
        t_edge_result     r;
        w = 32'(width_reg);
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        h = 32'(height_reg);
        if (h < 3) h = 3;
        col = col_pos;
        row = row_pos;
        if (col >= MAX_W) col = MAX_W - 1;
        idx = COL_W'(col);
        last_col = (col + 1 >= w);
        last_row = (row + 1 >= h);
        top = two_back[idx];
        if (row >= 2 && col >= 2) begin
            r.red   = chan_distance(top_tail[1].red, px.red);
            r.green = chan_distance(top.green, row_tail[1].green);
            r.blue  = chan_distance(top_tail[1].blue, row_tail[1].blue);
            r.col   = COL_W'(col - 1);
            r.row   = 16'(row - 1);
            r.done  = last_col && last_row;
            expected_edges.push_back(r);
        end
        top_tail[1] = top_tail[0];
        top_tail[0] = top;
        two_back[idx] = one_back[idx];
        one_back[idx] = px;
        row_tail[1] = row_tail[0];
        row_tail[0] = px;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((row + 1) & 32'hFFFF);
        end else begin
            col_pos = col + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_result();
        t_edge_result want;
        if (expected_edges.size() == 0) begin
            $error("edge result transaction arrived with no result expected");
            o_fail_count++;
        end else begin
            want = expected_edges.pop_front();
            check_field("edge_red", 32'(want.red), 32'(i_m_tdata[7:0]));
            check_field("edge_green", 32'(want.green), 32'(i_m_tdata[15:8]));
            check_field("edge_blue", 32'(want.blue), 32'(i_m_tdata[23:16]));
            check_field("out_col", 32'(want.col), 32'(i_m_tdata[24 +: COL_W]));
            check_field("out_row", 32'(want.row), 32'(i_m_tdata[24 + COL_W +: 16]));
            check_field("frame_done", 32'(want.done), 32'(i_m_tlast));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            row_tail[0] = '0;
            row_tail[1] = '0;
            top_tail[0] = '0;
            top_tail[1] = '0;
            col_pos = 0;
            row_pos = 0;
            expected_edges.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predict_pixel(t_pixel'(i_s_tdata));
                o_pixels_seen++;
            end
            if (i_m_tvalid && i_m_tready) begin
                check_result();
                o_results_seen++;
            end
            // A register write takes effect from the next pixel on.
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_FRAME_WIDTH) begin
                    width_reg = i_cfg_wdata[11:0];
                end else if (i_cfg_addr == REG_FRAME_HEIGHT) begin
                    height_reg = i_cfg_wdata[15:0];
                end
            end
        end
        o_pending = expected_edges.size();
    end

endmodule

[tb/sv/tb_diagonal_difference_edge_filter_top.sv]
// Testbench top that streams raster frames into the diagonal difference edge filter.
`timescale 1ns / 1ps

module tb_diagonal_difference_edge_filter_top;
    import ddef_pkg::*;

    localparam int unsigned MAX_W = 2048;
    localparam int unsigned OUT_W = (((40 + $clog2(MAX_W)) + 7) / 8) * 8;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    logic                              clk;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0]            cfg_addr = '0;
    logic [CfgDataWidth-1:0]           cfg_wdata = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [23:0]                       s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [OUT_W-1:0]                  m_tdata;
    logic                              m_tlast;

    int          fail_count;
    int          pending;
    int          pixels_seen;
    int          results_seen;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_len = 0;
    int unsigned random_items = 0;
    int unsigned idle_cycles = 0;

    diagonal_difference_edge_filter_top #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast)
    );

    edge_result_checker #(
        .MAX_W(MAX_W),
        .OUT_W(OUT_W)
    ) edge_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_pixels_seen (pixels_seen),
        .o_results_seen(results_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int unsigned n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when no transaction or register write happens for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] pick_level(input bit extremes_only);
        if (extremes_only || $urandom_range(3) == 0) begin
            return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic t_pixel make_pixel(input bit extremes_only);
        t_pixel px;
        px.red = pick_level(extremes_only);
        px.green = pick_level(extremes_only);
        px.blue = pick_level(extremes_only);
        return px;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_pixels(input int unsigned count, input bit extremes_only);
        for (int unsigned i = 0; i < count; i++) begin
            send_pixel(make_pixel(extremes_only));
        end
    endtask

    // Waits until every expected result is out, then lets the pipeline run empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_frame_size(input logic [15:0] width_word, input logic [15:0] height_word);
        settle();
        cfg_we <= 1'b1;
        cfg_addr <= REG_FRAME_WIDTH;
        cfg_wdata <= width_word;
        @(negedge clk);
        cfg_addr <= REG_FRAME_HEIGHT;
        cfg_wdata <= height_word;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Whole frames of random size, mostly small, with clamped sizes now and then.
    task automatic run_random(input int unsigned until_total);
        int unsigned pick;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned w_eff;
        int unsigned h_eff;
        while (random_items < until_total) begin
            pick = $urandom_range(9);
            if (pick == 0) w_raw = $urandom_range(2);
            else if (pick == 1) w_raw = $urandom_range(40, 13);
            else w_raw = $urandom_range(12, 3);
            h_raw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(7, 3);
            w_eff = (w_raw < 3) ? 3 : w_raw;
            h_eff = (h_raw < 3) ? 3 : h_raw;
            // The bits above the 12-bit width field must be ignored.
            set_frame_size({4'($urandom_range(15)), 12'(w_raw)}, 16'(h_raw));
            send_pixels(w_eff * h_eff, 1'b0);
            random_items += w_eff * h_eff;
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 82;

        // Sizes below the minimum clamp to 3x3; extreme channel values only.
        set_frame_size(16'd0, 16'd2);
        send_pixels(9, 1'b1);
        // Upper bits of the width word are dropped, leaving 4; height 1 acts as 3.
        set_frame_size(16'hF004, 16'd1);
        send_pixels(12, 1'b1);

        // Shrink mid-frame: column 6 of row 3 becomes past the last position and wraps.
        set_frame_size(16'd8, 16'd6);
        send_pixels(8 * 3 + 6, 1'b1);
        set_frame_size(16'd4, 16'd4);
        send_pixels(1, 1'b1);
        send_pixels(16, 1'b1);

        // Tallest height, then cut short mid-frame so that row 4 is the last one.
        set_frame_size(16'd3, 16'hFFFF);
        send_pixels(12, 1'b1);
        set_frame_size(16'd3, 16'd5);
        send_pixels(3, 1'b1);

        run_random(480);

        send_idle_pct = 82;
        recv_idle_pct = 37;
        run_random(960);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Long receiver stall with the sender at full rate, so the input backs up.
        set_frame_size(16'd10, 16'd6);
        hold_len = HOLD_OFF_CYCLES;
        send_pixels(60, 1'b0);
        random_items += 60;

        run_random(1450);
        settle();

        $display("Run covered %0d pixels and %0d edge results in frames from 3x3 to 40 columns,",
                 pixels_seen, results_seen);
        $display("with clamped sizes, mid-frame resizes, back-pressure and a long output stall.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
src/ddef_pkg.sv
src/ddef_line_buf.sv
src/diagonal_difference_edge_filter_top.sv
tb/sv/edge_result_checker.sv
tb/sv/tb_diagonal_difference_edge_filter_top.sv
